@@ rtl/sot_pkg.sv @@
// ----------------------------------------------------------------------------
// sot_pkg
// Types, mode codes and register indexes shared by the on/off timer.
// ----------------------------------------------------------------------------
package sot_pkg;

	localparam int MinuteW = 11;
	localparam int ModeW   = 3;
	localparam int DayW    = 3;
	localparam int MaskW   = 8;
	localparam int ActionW = 8;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 11;

	// Result queue: two words per tick at most, so four entries leave room for a
	// tick's results while the consumer stalls and older words wait.
	localparam int FifoDepth = 4;
	localparam int FifoPtrW  = $clog2(FifoDepth);
	localparam int FifoCntW  = $clog2(FifoDepth + 1);

	localparam logic [ModeW-1:0] MODE_SLEEP       = 3'd0;
	localparam logic [ModeW-1:0] MODE_PERIOD_WAIT = 3'd1;
	localparam logic [ModeW-1:0] MODE_PERIOD      = 3'd2;
	localparam logic [ModeW-1:0] MODE_COUNT_WAIT  = 3'd3;
	localparam logic [ModeW-1:0] MODE_COUNT       = 3'd4;
	localparam logic [ModeW-1:0] MODE_WEEKLY_WAIT = 3'd5;
	localparam logic [ModeW-1:0] MODE_WEEKLY      = 3'd6;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_ARM  = 1'b1;

	localparam logic [CfgIdxW-1:0] REG_ARMED_MODE   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_START_MINUTE = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_END_MINUTE   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_DAY_MASK     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_START_ACTION = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_END_ACTION   = 3'd5;

	typedef struct packed {
		logic               command;
		logic [MinuteW-1:0] now_minute;
		logic [DayW-1:0]    day_of_week;
	} in_word_t;

	typedef struct packed {
		logic               has_action;
		logic [ActionW-1:0] action;
		logic               was_sleeping;
		logic               last;
	} out_word_t;

endpackage

@@ rtl/scheduled_on_off_timer.sv @@
// ----------------------------------------------------------------------------
// scheduled_on_off_timer
// Minute-tick driven switch timer with period, countdown and weekly modes.
// ----------------------------------------------------------------------------
// One word is accepted per cycle while the input is not stalled. A word is
// registered, evaluated against the timer state once the result queue has
// room for two words, and its results (none for an arm, one or two for a
// tick) go into a four-entry result queue. The input stalls only while the
// queue holds more than two words, which two-result ticks can bring about even
// with the output never stalled; a new word is taken while the last is evaluated.
module scheduled_on_off_timer
	import sot_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_word_t            in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output out_word_t           out_word
);

	// Configuration registers
	logic [ModeW-1:0]   armed_mode_q;
	logic [MinuteW-1:0] start_minute_q;
	logic [MinuteW-1:0] end_minute_q;
	logic [MaskW-1:0]   day_mask_q;
	logic [ActionW-1:0] start_action_q;
	logic [ActionW-1:0] end_action_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_mode_q   <= MODE_SLEEP;
			start_minute_q <= '0;
			end_minute_q   <= '0;
			day_mask_q     <= '0;
			start_action_q <= '0;
			end_action_q   <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ARMED_MODE:   armed_mode_q   <= cfg_data[ModeW-1:0];
				REG_START_MINUTE: start_minute_q <= cfg_data[MinuteW-1:0];
				REG_END_MINUTE:   end_minute_q   <= cfg_data[MinuteW-1:0];
				REG_DAY_MASK:     day_mask_q     <= cfg_data[MaskW-1:0];
				REG_START_ACTION: start_action_q <= cfg_data[ActionW-1:0];
				REG_END_ACTION:   end_action_q   <= cfg_data[ActionW-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	logic     valid_s1;
	in_word_t word_s1;
	logic     adv_s1;
	logic     in_take;

	logic [FifoCntW-1:0] count_q;

	assign adv_s1   = valid_s1 && (count_q <= FifoCntW'(FifoDepth - 2));
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || adv_s1) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= in_word;
		end
	end

	// Timer state
	logic [ModeW-1:0]   mode_q;
	logic [MinuteW-1:0] ref_q;
	logic [MinuteW-1:0] span_q;

	logic [ModeW-1:0]   mode_n;
	logic [MinuteW-1:0] ref_n;
	logic [MinuteW-1:0] span_n;

	logic               sleeping;
	logic               day_on;
	logic               win_ok;
	logic               win_stop;
	logic               win_start;
	logic [MinuteW-1:0] past;
	logic               cd_stop;
	logic [ActionW-1:0] act0;
	logic [ActionW-1:0] act1;
	logic [1:0]         n_act;
	logic [1:0]         n_push;
	out_word_t          w0;
	out_word_t          w1;

	assign sleeping  = (mode_q == MODE_SLEEP);
	assign day_on    = day_mask_q[word_s1.day_of_week];
	assign win_ok    = ref_q < span_q;
	assign win_stop  = win_ok && (word_s1.now_minute >= span_q);
	assign win_start = win_ok && !win_stop && (word_s1.now_minute >= ref_q);

	// A minute behind the reference is checked directly and ends the countdown,
	// since its wrapped elapsed time need not exceed the span.
	assign past    = word_s1.now_minute - ref_q;
	assign cd_stop = (span_q != '0) && ((word_s1.now_minute < ref_q) || (span_q <= past));

	always_comb begin
		mode_n = mode_q;
		ref_n  = ref_q;
		span_n = span_q;
		act0   = '0;
		act1   = '0;
		n_act  = 2'd0;
		if (word_s1.command == CMD_ARM) begin
			mode_n = armed_mode_q;
			ref_n  = start_minute_q;
			span_n = end_minute_q;
		end else begin
			case (mode_q)
				MODE_PERIOD_WAIT: begin
					if (win_start) begin
						act0   = start_action_q;
						n_act  = 2'd1;
						mode_n = MODE_PERIOD;
					end
				end
				MODE_PERIOD: begin
					if (win_stop) begin
						act0   = end_action_q;
						n_act  = 2'd1;
						mode_n = MODE_SLEEP;
					end
				end
				MODE_COUNT_WAIT, MODE_COUNT: begin
					if (mode_q == MODE_COUNT_WAIT) begin
						act0   = start_action_q;
						n_act  = 2'd1;
						mode_n = MODE_COUNT;
					end
					if (span_q != '0) begin
						if (cd_stop) begin
							ref_n  = '0;
							span_n = '0;
							mode_n = MODE_SLEEP;
							if (n_act == 2'd0) begin
								act0  = end_action_q;
								n_act = 2'd1;
							end else begin
								act1  = end_action_q;
								n_act = 2'd2;
							end
						end else begin
							ref_n  = word_s1.now_minute;
							span_n = span_q - past;
						end
					end
				end
				MODE_WEEKLY_WAIT: begin
					if (day_on && win_start) begin
						act0   = start_action_q;
						n_act  = 2'd1;
						mode_n = MODE_WEEKLY;
					end
				end
				MODE_WEEKLY: begin
					if (!day_on || win_stop) begin
						act0   = end_action_q;
						n_act  = 2'd1;
						mode_n = MODE_WEEKLY_WAIT;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		w0.has_action   = (n_act != 2'd0);
		w0.action       = act0;
		w0.was_sleeping = sleeping;
		w0.last         = (n_act != 2'd2);
		w1.has_action   = 1'b1;
		w1.action       = act1;
		w1.was_sleeping = sleeping;
		w1.last         = 1'b1;
		if (word_s1.command == CMD_ARM) begin
			n_push = 2'd0;
		end else if (n_act == 2'd2) begin
			n_push = 2'd2;
		end else begin
			n_push = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SLEEP;
			ref_q  <= '0;
			span_q <= '0;
		end else if (adv_s1) begin
			mode_q <= mode_n;
			ref_q  <= ref_n;
			span_q <= span_n;
		end
	end

	// Result queue
	out_word_t           fifo_q [FifoDepth];
	logic [FifoPtrW-1:0] wr_q;
	logic [FifoPtrW-1:0] rd_q;
	logic [FifoPtrW-1:0] wr_next;
	logic                pop;
	logic [1:0]          push;

	assign wr_next   = wr_q + FifoPtrW'(1);
	assign push      = adv_s1 ? n_push : 2'd0;
	assign out_valid = (count_q != '0);
	assign out_word  = fifo_q[rd_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			fifo_q[wr_q] <= w0;
		end
		if (push == 2'd2) begin
			fifo_q[wr_next] <= w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FifoPtrW'(push);
			rd_q    <= rd_q + FifoPtrW'(pop);
			count_q <= count_q + FifoCntW'(push) - FifoCntW'(pop);
		end
	end

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FifoCntW'(FifoDepth))
		else $error("result queue count beyond depth");

	a_no_adv_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > FifoCntW'(FifoDepth - 2)) |-> !adv_s1)
		else $error("word evaluated without room for two results");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_arm_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (word_s1.command == CMD_ARM)) |=>
		((mode_q == $past(armed_mode_q)) && (span_q == $past(end_minute_q))))
		else $error("arm did not load the mode and span");

endmodule

@@ verif/tb_scheduled_on_off_timer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scheduled_on_off_timer
// Self-checking bench for the minute-tick on/off timer. A short directed
// table walks reset behavior, every mode and the corner cases. Random phases
// follow, each with its own register setting and mostly well-formed tick
// runs. Every accepted word is run through a local copy of the timer state,
// and each output word is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_scheduled_on_off_timer;
	import sot_pkg::*;

	localparam int RandomItems = 1350;
	localparam int SettleCycles = 6;
	localparam int CycleLimit = 500000;
	localparam logic [ModeW-1:0] MODE_INERT = 3'd7;

	typedef enum logic [1:0] {SW_KEEP, SW_ON, SW_OFF} switch_e;

	typedef struct {
		bit                  is_reg;
		logic [CfgIdxW-1:0]  idx;
		logic [CfgDataW-1:0] data;
		in_word_t            word;
		bit                  typed;
		int                  want_n;
		out_word_t           want;
	} drill_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_write;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_stall;
	in_word_t            in_word;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_word_t           out_word;

	// Local copy of the registers and of the timer state.
	logic [ModeW-1:0]   r_mode;
	logic [MinuteW-1:0] r_start;
	logic [MinuteW-1:0] r_end;
	logic [MaskW-1:0]   r_mask;
	logic [ActionW-1:0] r_on_act;
	logic [ActionW-1:0] r_off_act;
	logic [ModeW-1:0]   tm_mode;
	logic [MinuteW-1:0] tm_ref;
	logic [MinuteW-1:0] tm_span;

	out_word_t  timer_results[$];
	drill_row_t drill_plan[$];
	int         errors = 0;
	int         random_sent = 0;
	int         burst_left = 0;
	int         stall_style = 0;
	int         stall_left = 0;
	int         cycle_count = 0;

	scheduled_on_off_timer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic switch_e window_switch(logic [MinuteW-1:0] now);
		if (tm_ref < tm_span) begin
			if (now >= tm_span) return SW_OFF;
			if (now >= tm_ref) return SW_ON;
		end
		return SW_KEEP;
	endfunction

	// The elapsed time wraps in 16 bits, so a tick earlier than the reference
	// always uses up the remaining span.
	function automatic switch_e countdown_switch(logic [MinuteW-1:0] now);
		logic [15:0] elapsed;
		if (tm_span == '0) return SW_KEEP;
		elapsed = {5'd0, now} - {5'd0, tm_ref};
		tm_ref = now;
		if ({5'd0, tm_span} > elapsed) begin
			tm_span = tm_span - elapsed[MinuteW-1:0];
			return SW_KEEP;
		end
		tm_span = '0;
		tm_ref = '0;
		return SW_OFF;
	endfunction

	function automatic void advance_timer(in_word_t w);
		logic [ActionW-1:0] acts[2];
		int                 n;
		logic               sleeping;
		logic               day_on;
		out_word_t          r;
		n = 0;
		if (w.command == CMD_ARM) begin
			tm_mode = r_mode;
			tm_ref = r_start;
			tm_span = r_end;
			return;
		end
		sleeping = (tm_mode == MODE_SLEEP);
		day_on = r_mask[w.day_of_week];
		case (tm_mode)
			MODE_PERIOD_WAIT: begin
				if (window_switch(w.now_minute) == SW_ON) begin
					acts[n] = r_on_act;
					n++;
					tm_mode = MODE_PERIOD;
				end
			end
			MODE_PERIOD: begin
				if (window_switch(w.now_minute) == SW_OFF) begin
					acts[n] = r_off_act;
					n++;
					tm_mode = MODE_SLEEP;
				end
			end
			MODE_COUNT_WAIT, MODE_COUNT: begin
				if (tm_mode == MODE_COUNT_WAIT) begin
					acts[n] = r_on_act;
					n++;
					tm_mode = MODE_COUNT;
				end
				if (countdown_switch(w.now_minute) == SW_OFF) begin
					acts[n] = r_off_act;
					n++;
					tm_mode = MODE_SLEEP;
				end
			end
			MODE_WEEKLY_WAIT: begin
				if (day_on && window_switch(w.now_minute) == SW_ON) begin
					acts[n] = r_on_act;
					n++;
					tm_mode = MODE_WEEKLY;
				end
			end
			MODE_WEEKLY: begin
				if (!day_on || window_switch(w.now_minute) == SW_OFF) begin
					acts[n] = r_off_act;
					n++;
					tm_mode = MODE_WEEKLY_WAIT;
				end
			end
			default: begin
			end
		endcase
		if (n == 0) begin
			r.has_action = 1'b0;
			r.action = '0;
			r.was_sleeping = sleeping;
			r.last = 1'b1;
			timer_results.push_back(r);
		end else begin
			for (int k = 0; k < n; k++) begin
				r.has_action = 1'b1;
				r.action = acts[k];
				r.was_sleeping = sleeping;
				r.last = (k == n - 1);
				timer_results.push_back(r);
			end
		end
	endfunction

	function automatic in_word_t make_word(logic cmd, int now, int dow);
		in_word_t w;
		w.command = cmd;
		w.now_minute = now[MinuteW-1:0];
		w.day_of_week = dow[DayW-1:0];
		return w;
	endfunction

	function automatic out_word_t make_result(logic has, int act, logic slp);
		out_word_t r;
		r.has_action = has;
		r.action = act[ActionW-1:0];
		r.was_sleeping = slp;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic int pick_byte();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic row_reg(logic [CfgIdxW-1:0] idx, int data);
		drill_row_t row;
		row = '{default: '0};
		row.is_reg = 1'b1;
		row.idx = idx;
		row.data = data[CfgDataW-1:0];
		drill_plan.push_back(row);
	endtask

	task automatic row_word(logic cmd, int now, int dow);
		drill_row_t row;
		row = '{default: '0};
		row.word = make_word(cmd, now, dow);
		drill_plan.push_back(row);
	endtask

	task automatic row_known(logic cmd, int now, int dow, int n, out_word_t want);
		drill_row_t row;
		row = '{default: '0};
		row.word = make_word(cmd, now, dow);
		row.typed = 1'b1;
		row.want_n = n;
		row.want = want;
		drill_plan.push_back(row);
	endtask

	// Called at a falling edge; leaves cfg_write high, the caller lowers it.
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_ARMED_MODE:   r_mode = data[ModeW-1:0];
			REG_START_MINUTE: r_start = data[MinuteW-1:0];
			REG_END_MINUTE:   r_end = data[MinuteW-1:0];
			REG_DAY_MASK:     r_mask = data[MaskW-1:0];
			REG_START_ACTION: r_on_act = data[ActionW-1:0];
			REG_END_ACTION:   r_off_act = data[ActionW-1:0];
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	// An arm word gives no output, so the wait runs on past the last result
	// before the registers may change.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (timer_results.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic send_word(in_word_t w, bit typed, int want_n, out_word_t want);
		int gap;
		int queued;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end else begin
			burst_left--;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		queued = timer_results.size();
		advance_timer(w);
		if (typed) begin
			while (timer_results.size() > queued) void'(timer_results.pop_back());
			if (want_n > 0) timer_results.push_back(want);
		end
		@(negedge clk);
	endtask

	task automatic run_phase(int count);
		int               cur;
		int               day;
		int               start_v;
		int               end_v;
		int               pick;
		logic [ModeW-1:0] mode_v;
		wait_idle();
		mode_v = ModeW'($urandom_range(0, 7));
		pick = $urandom_range(0, 19);
		start_v = (pick == 0) ? 0 : (pick == 1) ? 1439 : (pick == 2) ? 2047 :
			$urandom_range(0, 1439);
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			end_v = $urandom_range(0, 2047);
		end else if (pick == 1) begin
			end_v = ($urandom_range(0, 1) != 0) ? 1439 : 0;
		end else if (mode_v == MODE_COUNT_WAIT || mode_v == MODE_COUNT) begin
			end_v = $urandom_range(1, 60);
		end else begin
			end_v = start_v + $urandom_range(1, 240);
			if (end_v > 1439) end_v = 1439;
		end
		write_reg(REG_ARMED_MODE, {8'd0, mode_v});
		write_reg(REG_START_MINUTE, start_v[CfgDataW-1:0]);
		write_reg(REG_END_MINUTE, end_v[CfgDataW-1:0]);
		write_reg(REG_DAY_MASK, CfgDataW'(pick_byte()));
		write_reg(REG_START_ACTION, CfgDataW'(pick_byte()));
		write_reg(REG_END_ACTION, CfgDataW'(pick_byte()));
		cfg_write <= 1'b0;

		// Ticks start a little before the window and walk forward through it.
		if (start_v > 1439) cur = $urandom_range(0, 1439);
		else cur = (start_v + 1440 - $urandom_range(0, 30)) % 1440;
		day = $urandom_range(0, 7);
		send_word(make_word(CMD_ARM, cur, day), 1'b0, 0, '0);
		random_sent++;
		for (int i = 1; i < count; i++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				send_word(make_word(CMD_ARM, $urandom_range(0, 2047), $urandom_range(0, 7)),
					1'b0, 0, '0);
			end else if (pick == 1) begin
				send_word(make_word(CMD_TICK, $urandom_range(0, 2047), $urandom_range(0, 7)),
					1'b0, 0, '0);
			end else begin
				if (pick == 2) day = $urandom_range(0, 7);
				cur += $urandom_range(0, 20);
				if (cur >= 1440) begin
					cur -= 1440;
					day = (day + 1) % 8;
				end
				send_word(make_word(CMD_TICK, cur, day), 1'b0, 0, '0);
			end
			random_sent++;
		end
	endtask

	task automatic report(string field, int want, int got);
		$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (timer_results.size() == 0) begin
				$display("%0t ns: unexpected word, expected none, actual %h", $time, out_word);
				errors++;
			end else begin
				out_word_t want;
				want = timer_results.pop_front();
				if (out_word.has_action !== want.has_action)
					report("has_action", int'(want.has_action), int'(out_word.has_action));
				if (out_word.action !== want.action)
					report("action", int'(want.action), int'(out_word.action));
				if (out_word.was_sleeping !== want.was_sleeping)
					report("was_sleeping", int'(want.was_sleeping),
						int'(out_word.was_sleeping));
				if (out_word.last !== want.last)
					report("last", int'(want.last), int'(out_word.last));
			end
		end
	end

	// The receiver picks a new stall habit whenever its current one runs out.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 4);
			stall_left = $urandom_range(50, 300);
		end else begin
			stall_left--;
		end
		case (stall_style)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			3: out_stall <= ~out_stall;
			default: out_stall <= ($urandom_range(0, 9) < 8);
		endcase
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		bit writing;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_word = '0;
		r_mode = MODE_SLEEP;
		r_start = '0;
		r_end = '0;
		r_mask = '0;
		r_on_act = '0;
		r_off_act = '0;
		tm_mode = MODE_SLEEP;
		tm_ref = '0;
		tm_span = '0;

		// Straight out of reset the timer sleeps and every register is zero.
		row_known(CMD_TICK, 0, 0, 1, make_result(1'b0, 0, 1'b1));
		row_known(CMD_TICK, 2047, 7, 1, make_result(1'b0, 0, 1'b1));
		row_known(CMD_ARM, 0, 0, 0, '0);
		// Period window from 100 to 200.
		row_reg(REG_ARMED_MODE, int'(MODE_PERIOD_WAIT));
		row_reg(REG_START_MINUTE, 100);
		row_reg(REG_END_MINUTE, 200);
		row_reg(REG_DAY_MASK, 'h81);
		row_reg(REG_START_ACTION, 'hFF);
		row_reg(REG_END_ACTION, 'h01);
		row_word(CMD_ARM, 0, 0);
		row_known(CMD_TICK, 99, 0, 1, make_result(1'b0, 0, 1'b0));
		row_known(CMD_TICK, 100, 0, 1, make_result(1'b1, 'hFF, 1'b0));
		row_known(CMD_TICK, 199, 0, 1, make_result(1'b0, 0, 1'b0));
		row_known(CMD_TICK, 200, 0, 1, make_result(1'b1, 'h01, 1'b0));
		row_known(CMD_TICK, 300, 0, 1, make_result(1'b0, 0, 1'b1));
		// Countdown with a zero span starts and then never ends.
		row_reg(REG_ARMED_MODE, int'(MODE_COUNT_WAIT));
		row_reg(REG_START_MINUTE, 1439);
		row_reg(REG_END_MINUTE, 0);
		row_word(CMD_ARM, 0, 0);
		row_known(CMD_TICK, 5, 0, 1, make_result(1'b1, 'hFF, 1'b0));
		row_known(CMD_TICK, 6, 0, 1, make_result(1'b0, 0, 1'b0));
		// A tick before the reference minute wraps and ends the countdown.
		row_reg(REG_START_MINUTE, 1430);
		row_reg(REG_END_MINUTE, 10);
		row_word(CMD_ARM, 0, 0);
		row_word(CMD_TICK, 1435, 0);
		row_word(CMD_TICK, 3, 1);
		// One tick that both starts and ends the countdown.
		row_reg(REG_START_MINUTE, 0);
		row_reg(REG_END_MINUTE, 1);
		row_word(CMD_ARM, 0, 0);
		row_word(CMD_TICK, 1, 0);
		// Weekly window on days 0 and 7 only.
		row_reg(REG_ARMED_MODE, int'(MODE_WEEKLY_WAIT));
		row_reg(REG_START_MINUTE, 600);
		row_reg(REG_END_MINUTE, 700);
		row_reg(REG_START_ACTION, 'h00);
		row_reg(REG_END_ACTION, 'hFF);
		row_word(CMD_ARM, 0, 0);
		row_word(CMD_TICK, 650, 1);
		row_word(CMD_TICK, 650, 7);
		row_word(CMD_TICK, 700, 0);
		// The spare mode code does nothing and does not count as sleeping.
		row_reg(REG_ARMED_MODE, int'(MODE_INERT));
		row_reg(REG_START_MINUTE, 2047);
		row_reg(REG_END_MINUTE, 2047);
		row_word(CMD_ARM, 0, 0);
		row_known(CMD_TICK, 0, 0, 1, make_result(1'b0, 0, 1'b0));
		// A window that does not increase keeps the current mode.
		row_reg(REG_ARMED_MODE, int'(MODE_PERIOD));
		row_reg(REG_START_MINUTE, 500);
		row_reg(REG_END_MINUTE, 400);
		row_word(CMD_ARM, 0, 0);
		row_word(CMD_TICK, 450, 0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		writing = 1'b0;
		foreach (drill_plan[i]) begin
			if (drill_plan[i].is_reg) begin
				if (!writing) wait_idle();
				write_reg(drill_plan[i].idx, drill_plan[i].data);
				writing = 1'b1;
			end else begin
				if (writing) cfg_write <= 1'b0;
				writing = 1'b0;
				send_word(drill_plan[i].word, drill_plan[i].typed, drill_plan[i].want_n,
					drill_plan[i].want);
			end
		end

		while (random_sent < RandomItems) run_phase($urandom_range(10, 40));
		wait_idle();

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
